### hw/rtl/tcw_pkg.sv
// shared types and constants of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    typedef struct packed {
        logic wr_en;
        logic row_inc;
    } put_ctl_t;

endpackage

### hw/rtl/tcw_put_step.sv
// character decode and cursor column step for one put
`timescale 1ns / 1ps

module tcw_put_step #(
    parameter int COLUMNS = 80
) (
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [$clog2(COLUMNS)-1:0]   col,
    output tcw_pkg::put_ctl_t            ctl,
    output logic [$clog2(COLUMNS)-1:0]   col_next,
    output logic [$clog2(COLUMNS)-1:0]   wr_col,
    output logic [tcw_pkg::CHAR_W-1:0]   wr_char
);

    localparam int CW = $clog2(COLUMNS);

    logic [CW:0] col_ext;
    logic [CW:0] sum;

    assign col_ext = {1'b0, col};

    always_comb
    begin
        sum         = col_ext;
        ctl.wr_en   = 1'b0;
        ctl.row_inc = 1'b0;
        wr_col      = col;
        wr_char     = char_code;
        case (char_code)
            tcw_pkg::CH_LF:
            begin
                sum         = '0;
                ctl.row_inc = 1'b1;
            end
            tcw_pkg::CH_CR:
            begin
                sum = '0;
            end
            tcw_pkg::CH_TAB:
            begin
                sum = (col_ext + (CW+1)'(4)) & ~((CW+1)'(3));
            end
            tcw_pkg::CH_BS:
            begin
                if (col != '0)
                begin
                    sum       = col_ext - (CW+1)'(1);
                    ctl.wr_en = 1'b1;
                    wr_col    = col - CW'(1);
                    wr_char   = tcw_pkg::CH_BLANK;
                end
            end
            default:
            begin
                ctl.wr_en = 1'b1;
                sum       = col_ext + (CW+1)'(1);
            end
        endcase
        // column overflow wraps to the next row
        if (sum >= (CW+1)'(COLUMNS))
        begin
            col_next    = '0;
            ctl.row_inc = 1'b1;
        end
        else
        begin
            col_next = sum[CW-1:0];
        end
    end

endmodule

### hw/rtl/text_console_writer.sv
// top level of the text console writer: cursor control and screen store
`timescale 1ns / 1ps

// Character-cell console with a COLUMNS x ROWS screen store of 16-bit cells
// (character low byte, attribute high byte) in one single-port synchronous RAM.
// Rows are kept as a ring with a top-row pointer, so a scroll rewrites only the
// new bottom row, and one valid flag per row stands for rows that were not
// written since reset or the last clear (they read as blanks in the attribute
// that was set at that clear or at reset); there is no clearing pass after reset.
// One transfer is taken at a time. Clear, an unused op and an out-of-range read
// go straight to ST_DONE. A put passes ST_PUT; a write (a printable character or
// a backspace off column 0) then passes ST_FILL when it is the first write to a
// row since the last clear (row fill), and ST_WRITE; a scroll then passes
// ST_SCROLL to blank the new bottom row; then ST_DONE. A read loops in ST_DIV,
// which splits cell_index into row and column by subtracting COLUMNS once a
// cycle, then passes ST_RREQ, ST_RWAIT and ST_DONE. Row fill and scroll write
// cells one by one through the one RAM write port. A new transfer is taken
// while the previous result still waits in the output register.

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7],
                                   // cursor_pos[22:12], cell_data[38:23], zero pad
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DIV    = 9'b000000010,
        ST_RREQ   = 9'b000000100,
        ST_RWAIT  = 9'b000001000,
        ST_PUT    = 9'b000010000,
        ST_FILL   = 9'b000100000,
        ST_WRITE  = 9'b001000000,
        ST_SCROLL = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    function automatic logic [RW-1:0] wrap_row(input logic [RW:0] s);
        if (s >= (RW+1)'(ROWS))
            wrap_row = RW'(s - (RW+1)'(ROWS));
        else
            wrap_row = s[RW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [RW-1:0]     top_reg, top_next;
    logic [RW-1:0]     prow_reg, prow_next;
    logic [RW-1:0]     lrow_reg, lrow_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     wcol_reg, wcol_next;
    logic [7:0]        wchar_reg, wchar_next;
    logic [10:0]       rem_reg, rem_next;
    logic [7:0]        op_char_reg, op_char_next;
    logic              scroll_reg, scroll_next;
    logic [ROWS-1:0]   valid_reg, valid_next;
    logic [7:0]        attr_reg, attr_next;
    logic [7:0]        clr_attr_reg, clr_attr_next;
    logic [15:0]       data_reg, data_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [39:0]       m_tdata_reg, m_tdata_next;

    logic [15:0]       screen_mem [CELLS];
    logic [15:0]       rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [15:0]       mem_wdata;
    logic [CW-1:0]     acol;

    tcw_pkg::put_ctl_t step_ctl;
    logic [CW-1:0]     step_col;
    logic [CW-1:0]     step_wcol;
    logic [7:0]        step_wchar;

    logic              in_xfer;
    logic              out_load;
    logic              row_last;
    logic [AW-1:0]     cur_pos;
    logic [1:0]        in_op;
    logic [10:0]       in_idx;

    tcw_put_step #(
        .COLUMNS(COLUMNS)
    ) u_put_step (
        .char_code(op_char_reg),
        .col      (col_reg),
        .ctl      (step_ctl),
        .col_next (step_col),
        .wr_col   (step_wcol),
        .wr_char  (step_wchar)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_op    = s_tuser;
    assign in_idx   = s_tdata[18:8];
    assign row_last = (row_reg == RW'(ROWS - 1));
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign cur_pos  = AW'(AW'(row_reg) * AW'(COLUMNS)) + AW'(col_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign acol     = (state_reg == ST_FILL || state_reg == ST_SCROLL) ? cnt_reg : wcol_reg;
    assign mem_addr = AW'(AW'(prow_reg) * AW'(COLUMNS)) + AW'(acol);
    assign mem_we   = (state_reg == ST_FILL) || (state_reg == ST_SCROLL)
                   || (state_reg == ST_WRITE);
    assign mem_re   = (state_reg == ST_RREQ);

    always_comb
    begin
        unique case (state_reg)
            ST_FILL:   mem_wdata = {clr_attr_reg, tcw_pkg::CH_BLANK};
            ST_SCROLL: mem_wdata = {attr_reg, tcw_pkg::CH_BLANK};
            default:   mem_wdata = {attr_reg, wchar_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= screen_mem[mem_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        top_next      = top_reg;
        prow_next     = prow_reg;
        lrow_next     = lrow_reg;
        cnt_next      = cnt_reg;
        wcol_next     = wcol_reg;
        wchar_next    = wchar_reg;
        rem_next      = rem_reg;
        op_char_next  = op_char_reg;
        scroll_next   = scroll_reg;
        valid_next    = valid_reg;
        attr_next     = cfg_wen ? cfg_wdata : attr_reg;
        clr_attr_next = clr_attr_reg;
        data_next     = data_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    data_next    = '0;
                    op_char_next = s_tdata[7:0];
                    case (in_op)
                        tcw_pkg::OP_PUT:
                        begin
                            state_next = ST_PUT;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            valid_next    = '0;
                            clr_attr_next = attr_reg;
                            col_next      = '0;
                            row_next      = '0;
                            top_next      = '0;
                            state_next    = ST_DONE;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            rem_next  = in_idx;
                            lrow_next = '0;
                            if ({21'b0, in_idx} >= 32'(CELLS))
                                state_next = ST_DONE;
                            else
                                state_next = ST_DIV;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= 11'(COLUMNS))
                begin
                    rem_next  = rem_reg - 11'(COLUMNS);
                    lrow_next = lrow_reg + RW'(1);
                end
                else
                begin
                    prow_next  = wrap_row({1'b0, lrow_reg} + {1'b0, top_reg});
                    wcol_next  = rem_reg[CW-1:0];
                    state_next = ST_RREQ;
                end
            end
            ST_RREQ:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                data_next  = valid_reg[prow_reg] ? rdata_reg
                                                 : {clr_attr_reg, tcw_pkg::CH_BLANK};
                state_next = ST_DONE;
            end
            ST_PUT:
            begin
                col_next    = step_col;
                scroll_next = step_ctl.row_inc && row_last;
                if (step_ctl.row_inc && !row_last)
                    row_next = row_reg + RW'(1);
                wcol_next  = step_wcol;
                wchar_next = step_wchar;
                prow_next  = wrap_row({1'b0, row_reg} + {1'b0, top_reg});
                cnt_next   = '0;
                if (step_ctl.wr_en)
                begin
                    state_next = valid_reg[prow_next] ? ST_WRITE : ST_FILL;
                end
                else if (step_ctl.row_inc && row_last)
                begin
                    // old top row becomes the new bottom row
                    prow_next  = top_reg;
                    top_next   = wrap_row({1'b0, top_reg} + (RW+1)'(1));
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(COLUMNS - 1))
                begin
                    valid_next[prow_reg] = 1'b1;
                    state_next           = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cnt_next = '0;
                if (scroll_reg)
                begin
                    prow_next  = top_reg;
                    top_next   = wrap_row({1'b0, top_reg} + (RW+1)'(1));
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(COLUMNS - 1))
                begin
                    valid_next[prow_reg] = 1'b1;
                    state_next           = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, data_reg, 11'(cur_pos), 5'(row_reg), 7'(col_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            top_reg      <= '0;
            valid_reg    <= '0;
            attr_reg     <= tcw_pkg::RESET_ATTR;
            clr_attr_reg <= tcw_pkg::RESET_ATTR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            top_reg      <= top_next;
            valid_reg    <= valid_next;
            attr_reg     <= attr_next;
            clr_attr_reg <= clr_attr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prow_reg    <= prow_next;
        lrow_reg    <= lrow_next;
        cnt_reg     <= cnt_next;
        wcol_reg    <= wcol_next;
        wchar_reg   <= wchar_next;
        rem_reg     <= rem_next;
        op_char_reg <= op_char_next;
        scroll_reg  <= scroll_next;
        data_reg    <= data_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

### hw/rtl/tcw_checker.sv
// port-level checks of the text console writer and their binding
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // cursor fields are exact only while they fit the port widths
    localparam bit NARROW = (COLUMNS <= 128) && (ROWS <= 32) && (COLUMNS * ROWS <= 2048);

    // one item at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input transfer accepted back to back");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && NARROW |->
            (32'(m_tdata[22:12]) == 32'(m_tdata[11:7]) * COLUMNS + 32'(m_tdata[6:0])))
        else $error("cursor position does not match column and row");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && NARROW |-> (32'(m_tdata[6:0]) < COLUMNS) && (32'(m_tdata[11:7]) < ROWS))
        else $error("cursor outside the screen");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (.*);

### tb/sv/console_checker.sv
// checker for the text console writer: predicts every result and compares it
`timescale 1ns / 1ps

module console_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7],
                                   // cursor_pos[22:12], cell_data[38:23], zero pad
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,
    output int          pending_results,
    output int          error_count
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [POS_W-1:0]  pos;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } console_result_t;

    logic [CELL_W-1:0] screen [CELLS];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ATTR_W-1:0] attr;
    console_result_t   expected_results [$];

    function automatic console_result_t predict_console_op(
        input logic [OP_W-1:0]    op,
        input logic [CHAR_W-1:0]  ch,
        input logic [INDEX_W-1:0] idx
    );
        console_result_t   res;
        logic [CELL_W-1:0] blank;
        int                i;
        blank         = {attr, CH_BLANK};
        res.cell_data = '0;
        if (op == OP_PUT)
        begin
            if (ch == CH_LF)
            begin
                cur_col = '0;
                cur_row = cur_row + 1'b1;
            end
            else if (ch == CH_CR)
            begin
                cur_col = '0;
            end
            else if (ch == CH_TAB)
            begin
                cur_col = (cur_col + COL_W'(4)) & ~COL_W'(3);
            end
            else if (ch == CH_BS)
            begin
                if (cur_col != 0)
                begin
                    cur_col = cur_col - 1'b1;
                    screen[int'(cur_row) * COLUMNS + int'(cur_col)] = blank;
                end
            end
            else
            begin
                screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {attr, ch};
                cur_col = cur_col + 1'b1;
            end
            if (int'(cur_col) >= COLUMNS)
            begin
                cur_col = '0;
                cur_row = cur_row + 1'b1;
            end
            // scroll up one row
            if (int'(cur_row) >= ROWS)
            begin
                for (i = COLUMNS; i < CELLS; i++)
                    screen[i - COLUMNS] = screen[i];
                for (i = CELLS - COLUMNS; i < CELLS; i++)
                    screen[i] = blank;
                cur_row = ROW_W'(ROWS - 1);
            end
        end
        else if (op == OP_CLEAR)
        begin
            for (i = 0; i < CELLS; i++)
                screen[i] = blank;
            cur_col = '0;
            cur_row = '0;
        end
        else if (op == OP_READ)
        begin
            if (int'(idx) < CELLS)
                res.cell_data = screen[idx];
        end
        res.col = cur_col;
        res.row = cur_row;
        res.pos = POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        console_result_t got;
        console_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = {RESET_ATTR, CH_BLANK};
            cur_col     = '0;
            cur_row     = '0;
            attr        = RESET_ATTR;
            error_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_wen)
                attr = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_console_op(
                    s_tuser, s_tdata[CHAR_W-1:0], s_tdata[CHAR_W +: INDEX_W]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[38:0];
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer: tdata %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.col !== want.col)
                    begin
                        $error("cursor_col mismatch: expected %0d, actual %0d",
                               want.col, got.col);
                        error_count++;
                    end
                    if (got.row !== want.row)
                    begin
                        $error("cursor_row mismatch: expected %0d, actual %0d",
                               want.row, got.row);
                        error_count++;
                    end
                    if (got.pos !== want.pos)
                    begin
                        $error("cursor_pos mismatch: expected %0d, actual %0d",
                               want.pos, got.pos);
                        error_count++;
                    end
                    if (got.cell_data !== want.cell_data)
                    begin
                        $error("cell_data mismatch: expected %h, actual %h",
                               want.cell_data, got.cell_data);
                        error_count++;
                    end
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

### tb/sv/testbench.sv
// testbench top for the text console writer: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELLS         = COLUMNS * ROWS;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 275;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 2 * COLUMNS + 8;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // char_code[7:0], cell_index[18:8], zero pad
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // cursor_col[6:0], cursor_row[11:7],
                            // cursor_pos[22:12], cell_data[38:23], zero pad
    logic        cfg_wen;
    logic [7:0]  cfg_wdata;

    int pending_results;
    int error_count;
    int src_idle_pct;
    int dst_idle_pct;
    int items_sent;
    int stall_cycles;

    always #4 clk = ~clk;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .pending_results (pending_results),
        .error_count     (error_count)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, idx, ch};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, INDEX_W'($urandom_range(2047)));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic random_burst();
        int                 kind;
        int                 n;
        int                 pick;
        logic [INDEX_W-1:0] idx;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            // a line of text with an optional line ending
            n = $urandom_range(90);
            repeat (n)
                put_char(CHAR_W'($urandom_range(255)));
            pick = $urandom_range(3);
            if (pick == 0)
            begin
                put_char(CH_LF);
            end
            else if (pick == 1)
            begin
                put_char(CH_CR);
                put_char(CH_LF);
            end
            else if (pick == 2)
            begin
                put_char(CH_CR);
            end
        end
        else if (kind < 52)
        begin
            repeat ($urandom_range(1, 30))
                put_char(CH_LF);
        end
        else if (kind < 60)
        begin
            repeat ($urandom_range(1, 25))
                put_char(CH_TAB);
        end
        else if (kind < 68)
        begin
            repeat ($urandom_range(1, 6))
                put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
            repeat ($urandom_range(1, 10))
                put_char(CH_BS);
        end
        else if (kind < 95)
        begin
            repeat ($urandom_range(1, 6))
            begin
                pick = $urandom_range(9);
                if (pick < 4)
                    idx = INDEX_W'($urandom_range(CELLS - 1));
                else if (pick < 9)
                    idx = INDEX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
                else
                    idx = INDEX_W'($urandom_range(CELLS, 2047));
                send_item(OP_READ, CHAR_W'($urandom_range(255)), idx);
            end
        end
        else if (kind < 97)
        begin
            send_item(OP_CLEAR, CHAR_W'($urandom_range(255)),
                      INDEX_W'($urandom_range(2047)));
        end
        else
        begin
            send_item(OP_NONE, CHAR_W'($urandom_range(255)),
                      INDEX_W'($urandom_range(2047)));
        end
    endtask

    initial
    begin
        int                target;
        logic [ATTR_W-1:0] seg_attr;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_wen      = 1'b0;
        cfg_wdata    = '0;
        src_idle_pct = 32;
        dst_idle_pct = 64;
        items_sent   = 0;
        stall_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset attribute
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'hFF, INDEX_W'(CELLS - 1));
        send_item(OP_READ, 8'h00, 11'h7FF);
        send_item(OP_NONE, 8'hFF, 11'h7FF);
        send_item(OP_PUT, 8'h41, 11'h000);
        send_item(OP_PUT, 8'hFF, 11'h7FF);
        send_item(OP_PUT, 8'h00, 11'h555);
        send_item(OP_PUT, CH_BS, 11'h2AA);
        send_item(OP_READ, 8'h00, 11'd2);
        send_item(OP_READ, 8'h00, 11'd1);
        send_item(OP_PUT, CH_TAB, 11'h000);
        send_item(OP_PUT, CH_CR, 11'h000);
        send_item(OP_PUT, CH_BS, 11'h000);
        send_item(OP_PUT, CH_LF, 11'h000);
        send_item(OP_PUT, 8'h7E, 11'h000);
        send_item(OP_READ, 8'h00, INDEX_W'(COLUMNS));
        send_item(OP_CLEAR, 8'hAA, 11'h3FF);
        send_item(OP_READ, 8'h00, INDEX_W'(COLUMNS));
        send_item(OP_READ, 8'h00, 11'd0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            if (seg == 0)
                seg_attr = 8'h00;
            else if (seg == 1)
                seg_attr = 8'hFF;
            else
                seg_attr = ATTR_W'($urandom_range(255));
            write_attr(seg_attr);
            if (seg < 2)
            begin
                src_idle_pct = 32;
                dst_idle_pct = 64;
            end
            else if (seg < 4)
            begin
                src_idle_pct = 64;
                dst_idle_pct = 32;
            end
            else
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            target = items_sent + SEGMENT_ITEMS;
            while (items_sent < target)
                random_burst();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_put_step.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_checker.sv
tb/sv/console_checker.sv
tb/sv/testbench.sv
